// ===== rtl/double_hash_key_value_table_core_assert.svh =====
// Assertion macros for the double-hashed key-value table core.
// Depends on nothing; included by the top level only.
`ifndef DOUBLE_HASH_KEY_VALUE_TABLE_CORE_ASSERT_SVH
`define DOUBLE_HASH_KEY_VALUE_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define DHKV_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define DHKV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dhkv_pkg.sv =====
// Types, codes and microcode program of the double-hashed key-value table.
// No dependencies; used by double_hash_key_value_table_core.
`default_nettype none

package dhkv_pkg;

  localparam int TABLE_SIZE_DEF = 16;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_SEARCH   = 2'd1,
    OP_REMOVE   = 2'd2,
    OP_RESERVED = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_EMPTY = 2'd0,
    ST_LIVE  = 2'd1,
    ST_TOMB  = 2'd2
  } slot_st_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] old_value;
    logic               full_error;
    logic [4:0]         entry_total;
  } rsp_t;

  // Microcode addresses
  typedef enum logic [3:0] {
    U_CLEAR = 4'd0,
    U_IDLE  = 4'd1,
    U_MUL   = 4'd2,
    U_BACK  = 4'd3,
    U_FOLD  = 4'd4,
    U_HASH  = 4'd5,
    U_READ  = 4'd6,
    U_TEST  = 4'd7,
    U_FOUND = 4'd8,
    U_EMPTY = 4'd9,
    U_FULL  = 4'd10
  } uaddr_t;

  typedef enum logic [3:0] {
    ACT_CLEAR,
    ACT_ACCEPT,
    ACT_MUL,
    ACT_BACK,
    ACT_FOLD,
    ACT_HASH,
    ACT_READ,
    ACT_PROBE,
    ACT_FOUND,
    ACT_EMPTY,
    ACT_FULL
  } act_t;

  typedef enum logic [2:0] {
    COND_NEXT,      // fall through
    COND_ALWAYS,    // jump to target
    COND_WAIT,      // jump to target until start
    COND_CLR_MORE,  // jump to target while clear sweep runs
    COND_OP_BAD,    // jump to target on the reserved operation
    COND_DISPATCH   // hold while probing, else target + outcome
  } cond_t;

  // Probe outcome, added to the dispatch target
  localparam logic [1:0] OUT_FOUND = 2'd0;
  localparam logic [1:0] OUT_EMPTY = 2'd1;
  localparam logic [1:0] OUT_FULL  = 2'd2;

  typedef struct packed {
    act_t   act;
    cond_t  cond;
    logic   emit;
    uaddr_t target;
  } uword_t;

  function automatic uword_t ucode(uaddr_t a);
    uword_t w;
    w = '{act: ACT_ACCEPT, cond: COND_WAIT, emit: 1'b0, target: U_IDLE};
    unique case (a)
      U_CLEAR: w = '{act: ACT_CLEAR,  cond: COND_CLR_MORE, emit: 1'b0, target: U_CLEAR};
      U_IDLE:  w = '{act: ACT_ACCEPT, cond: COND_WAIT,     emit: 1'b0, target: U_IDLE};
      U_MUL:   w = '{act: ACT_MUL,    cond: COND_NEXT,     emit: 1'b0, target: U_BACK};
      U_BACK:  w = '{act: ACT_BACK,   cond: COND_NEXT,     emit: 1'b0, target: U_FOLD};
      U_FOLD:  w = '{act: ACT_FOLD,   cond: COND_NEXT,     emit: 1'b0, target: U_HASH};
      U_HASH:  w = '{act: ACT_HASH,   cond: COND_OP_BAD,   emit: 1'b0, target: U_EMPTY};
      U_READ:  w = '{act: ACT_READ,   cond: COND_NEXT,     emit: 1'b0, target: U_TEST};
      U_TEST:  w = '{act: ACT_PROBE,  cond: COND_DISPATCH, emit: 1'b0, target: U_FOUND};
      U_FOUND: w = '{act: ACT_FOUND,  cond: COND_ALWAYS,   emit: 1'b1, target: U_IDLE};
      U_EMPTY: w = '{act: ACT_EMPTY,  cond: COND_ALWAYS,   emit: 1'b1, target: U_IDLE};
      U_FULL:  w = '{act: ACT_FULL,   cond: COND_ALWAYS,   emit: 1'b1, target: U_IDLE};
      default: w = '{act: ACT_ACCEPT, cond: COND_ALWAYS,   emit: 1'b0, target: U_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/double_hash_key_value_table_core.sv =====
// Channel   | Signals                 | Handshake
// ----------+-------------------------+----------------------------------------
// request   | request (dhkv_pkg::req_t)| taken at an edge with start=1, busy=0
// response  | response (dhkv_pkg::rsp_t)| valid for one cycle while done=1
//
// After reset a clearing pass marks all TABLE_SIZE slots empty, one per cycle,
// with busy held high. Each item then passes the MUL, BACK and FOLD steps, which
// find both key remainders by reciprocal multiply; HASH sets up the probe, READ
// starts the first slot read, TEST does one slot memory read per probe, 1 to
// TABLE_SIZE probes, and FOUND, EMPTY or FULL settles the outcome. The reserved
// operation skips the probe, jumping from HASH to EMPTY. busy falls in the cycle
// done is shown, so the next item may be taken then. Results cannot be held off.
// Depends on dhkv_pkg and double_hash_key_value_table_core_assert.svh.
`default_nettype none
`include "double_hash_key_value_table_core_assert.svh"

module double_hash_key_value_table_core #(
  parameter int TABLE_SIZE = dhkv_pkg::TABLE_SIZE_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  dhkv_pkg::req_t request,
  output logic           done,
  output dhkv_pkg::rsp_t response
);

  localparam int IW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int RW = IW + 1;
  localparam int CW = $clog2(TABLE_SIZE + 1);
  localparam logic [RW-1:0] MOD_N    = RW'(TABLE_SIZE);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SIZE - 1);
  localparam logic [31:0]   DIV_N    = 32'(TABLE_SIZE);
  localparam logic [31:0]   DIV_M    = 32'(TABLE_SIZE - 1);
  localparam logic [31:0]   RECIP_N  = 32'(64'h1_0000_0000 / 64'(TABLE_SIZE));
  localparam logic [31:0]   RECIP_M  = 32'(64'h1_0000_0000 / 64'(TABLE_SIZE - 1));

  // Sequencer
  dhkv_pkg::uaddr_t upc, upc_next;
  dhkv_pkg::uword_t ctl;
  logic [IW-1:0]    clr;

  // Datapath registers
  dhkv_pkg::op_t    op_r;
  logic [31:0]      key_r;
  logic [31:0]      value_r;
  logic [31:0]      mag;
  logic [31:0]      quo_n, quo_m;
  logic [31:0]      back_n, back_m;
  logic [IW-1:0]    rem_n;
  logic [IW-1:0]    rem_m;
  logic [IW-1:0]    pos;
  logic [IW-1:0]    step;
  logic [IW-1:0]    idx;
  logic [CW-1:0]    count, count_next;

  // Slot memories
  dhkv_pkg::slot_st_t st_mem  [TABLE_SIZE];
  logic [31:0]        key_mem [TABLE_SIZE];
  logic [31:0]        val_mem [TABLE_SIZE];
  dhkv_pkg::slot_st_t rd_st;
  logic [31:0]        rd_key;
  logic [31:0]        rd_val;

  logic               st_we, key_we, val_we;
  logic [IW-1:0]      wa, rd_addr;
  dhkv_pkg::slot_st_t st_wd;

  logic               accept;
  logic [31:0]        in_bits, in_mag;
  logic [63:0]        prod_n, prod_m;
  logic [31:0]        dif_n, dif_m, red_n, red_m;
  logic [RW-1:0]      a_sum, step_nx, pos_sum, pos_adv;
  logic               is_found, is_empty, is_last, more;
  logic [1:0]         outcome;
  dhkv_pkg::rsp_t     rsp_next;
  logic [CW+4:0]      total_wide;

  assign busy   = (upc != dhkv_pkg::U_IDLE);
  assign accept = start && !busy;

  assign in_bits = request.key;
  assign in_mag  = in_bits[31] ? (~in_bits + 32'd1) : in_bits;

  // Reciprocal estimate of the quotient, short of the true one by at most one
  assign prod_n = {32'd0, mag} * {32'd0, RECIP_N};
  assign prod_m = {32'd0, mag} * {32'd0, RECIP_M};

  // What is left stays below twice the modulus: one subtract settles it
  assign dif_n = mag - back_n;
  assign dif_m = mag - back_m;
  assign red_n = (dif_n >= DIV_N) ? (dif_n - DIV_N) : dif_n;
  assign red_m = (dif_m >= DIV_M) ? (dif_m - DIV_M) : dif_m;

  // Make the step odd, then wrap
  assign a_sum   = {1'b0, rem_m} + (rem_m[0] ? RW'(2) : RW'(1));
  assign step_nx = (a_sum >= MOD_N) ? (a_sum - MOD_N) : a_sum;

  assign pos_sum = {1'b0, pos} + {1'b0, step};
  assign pos_adv = (pos_sum >= MOD_N) ? (pos_sum - MOD_N) : pos_sum;

  assign is_found = (rd_st == dhkv_pkg::ST_LIVE) && (rd_key == key_r);
  assign is_empty = (rd_st == dhkv_pkg::ST_EMPTY);
  assign is_last  = (idx == LAST_IDX);
  assign more     = !is_found && !is_empty && !is_last;
  assign outcome  = is_found ? dhkv_pkg::OUT_FOUND :
                    is_empty ? dhkv_pkg::OUT_EMPTY : dhkv_pkg::OUT_FULL;

  always_comb begin
    ctl = dhkv_pkg::ucode(upc);
    upc_next = dhkv_pkg::uaddr_t'(4'(upc) + 4'd1);
    unique case (ctl.cond)
      dhkv_pkg::COND_NEXT:     upc_next = dhkv_pkg::uaddr_t'(4'(upc) + 4'd1);
      dhkv_pkg::COND_ALWAYS:   upc_next = ctl.target;
      dhkv_pkg::COND_WAIT:     if (!start) upc_next = ctl.target;
      dhkv_pkg::COND_CLR_MORE: if (clr != LAST_IDX) upc_next = ctl.target;
      dhkv_pkg::COND_OP_BAD: begin
        if (op_r == dhkv_pkg::OP_RESERVED) upc_next = ctl.target;
      end
      dhkv_pkg::COND_DISPATCH: begin
        upc_next = more ? upc
                 : dhkv_pkg::uaddr_t'(4'(ctl.target) + {2'b00, outcome});
      end
      default: upc_next = dhkv_pkg::U_IDLE;
    endcase
  end

  // Memory write and read control, result and count update
  always_comb begin
    st_we      = 1'b0;
    key_we     = 1'b0;
    val_we     = 1'b0;
    st_wd      = dhkv_pkg::ST_EMPTY;
    wa         = pos;
    rd_addr    = pos;
    count_next = count;
    rsp_next   = '0;
    unique case (ctl.act)
      dhkv_pkg::ACT_CLEAR: begin
        st_we = 1'b1;
        wa    = clr;
      end
      dhkv_pkg::ACT_PROBE: begin
        if (more) rd_addr = IW'(pos_adv);
      end
      dhkv_pkg::ACT_FOUND: begin
        rsp_next.hit       = 1'b1;
        rsp_next.old_value = rd_val;
        if (op_r == dhkv_pkg::OP_INSERT) begin
          val_we = 1'b1;
        end else if (op_r == dhkv_pkg::OP_REMOVE) begin
          st_we = 1'b1;
          st_wd = dhkv_pkg::ST_TOMB;
          if (count != '0) count_next = count - CW'(1);
        end
      end
      dhkv_pkg::ACT_EMPTY: begin
        if (op_r == dhkv_pkg::OP_INSERT) begin
          st_we      = 1'b1;
          st_wd      = dhkv_pkg::ST_LIVE;
          key_we     = 1'b1;
          val_we     = 1'b1;
          count_next = count + CW'(1);
        end
      end
      dhkv_pkg::ACT_FULL: begin
        rsp_next.full_error = (op_r == dhkv_pkg::OP_INSERT);
      end
      default: ;
    endcase
    total_wide           = (CW + 5)'(count_next);
    rsp_next.entry_total = total_wide[4:0];
  end

  always_ff @(posedge clk) begin
    if (st_we) st_mem[wa] <= st_wd;
    rd_st <= st_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[wa] <= key_r;
    rd_key <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (val_we) val_mem[wa] <= value_r;
    rd_val <= val_mem[rd_addr];
  end

  // Sequencer state, live count and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      upc      <= dhkv_pkg::U_CLEAR;
      clr      <= '0;
      count    <= '0;
      done     <= 1'b0;
      response <= '0;
    end else begin
      upc   <= upc_next;
      count <= count_next;
      done  <= ctl.emit;
      if (ctl.act == dhkv_pkg::ACT_CLEAR) clr <= clr + IW'(1);
      if (ctl.emit) response <= rsp_next;
    end
  end

  // Item datapath
  always_ff @(posedge clk) begin
    unique case (ctl.act)
      dhkv_pkg::ACT_ACCEPT: begin
        if (accept) begin
          op_r    <= dhkv_pkg::op_t'(request.operation);
          key_r   <= request.key;
          value_r <= request.value;
          mag     <= in_mag;
        end
      end
      dhkv_pkg::ACT_MUL: begin
        quo_n <= prod_n[63:32];
        quo_m <= prod_m[63:32];
      end
      dhkv_pkg::ACT_BACK: begin
        back_n <= quo_n * DIV_N;
        back_m <= quo_m * DIV_M;
      end
      dhkv_pkg::ACT_FOLD: begin
        rem_n <= red_n[IW-1:0];
        rem_m <= red_m[IW-1:0];
      end
      dhkv_pkg::ACT_HASH: begin
        pos  <= rem_n;
        step <= IW'(step_nx);
        idx  <= '0;
      end
      dhkv_pkg::ACT_PROBE: begin
        if (more) begin
          pos <= IW'(pos_adv);
          idx <= idx + IW'(1);
        end
      end
      default: ;
    endcase
  end

  `DHKV_ASSERT_NEXT(a_single_result, clk, rst, done, !done,
                    "result strobe held for more than one cycle")
  `DHKV_ASSERT_NEXT(a_busy_after_accept, clk, rst, accept, busy,
                    "block not busy after taking an item")
  `DHKV_ASSERT_NOW(a_hit_not_full, clk, rst, done,
                   !(response.hit && response.full_error),
                   "hit and full flagged together")
  `DHKV_ASSERT_NOW(a_pos_in_range, clk, rst, upc == dhkv_pkg::U_TEST,
                   pos <= LAST_IDX, "probe slot outside the table")
  `DHKV_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CW'(TABLE_SIZE),
                   "live count above table size")

endmodule

`default_nettype wire

// ===== tb/double_hash_key_value_table_core_tb.sv =====
// Self-checking testbench for the double-hashed key-value table core.
// Predicts each reply from a shadow copy of the slot table, or takes it from a fixed row; needs dhkv_pkg and the core.
`default_nettype none

module double_hash_key_value_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          SLOTS        = dhkv_pkg::TABLE_SIZE_DEF;
  localparam int          RANDOM_ITEMS = 1180;
  localparam int          GAP_MAX      = 16;
  localparam int          IDLE_LIMIT   = 2000;
  localparam int          SETTLE       = 64;
  localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;

  typedef struct {
    dhkv_pkg::req_t item;
    bit             fixed;
    dhkv_pkg::rsp_t given;
  } table_row_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic done;
  dhkv_pkg::req_t request;
  dhkv_pkg::rsp_t response;

  // shadow of the slot table
  dhkv_pkg::slot_st_t shadow_state [SLOTS];
  logic signed [31:0] shadow_key  [SLOTS];
  logic signed [31:0] shadow_val  [SLOTS];
  logic [4:0]         shadow_live;

  dhkv_pkg::rsp_t     answers [$];
  table_row_t         directed_rows [$];
  logic signed [31:0] stored_keys [$];

  int unsigned faults      = 0;
  int unsigned items_sent  = 0;
  int unsigned replies     = 0;
  int unsigned hits_seen   = 0;
  int unsigned fulls_seen  = 0;
  int unsigned idle_cycles = 0;

  always #2 clk = ~clk;

  double_hash_key_value_table_core #(
    .TABLE_SIZE(SLOTS)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .response(response)
  );

  function automatic int unsigned abs_rem(longint k, longint m);
    longint r;
    r = k % m;
    return (r < 0) ? int'(-r) : int'(r);
  endfunction

  // Probe the shadow table exactly as the core does and apply the operation.
  // A zero stride needs an odd table size, so it cannot occur here.
  function automatic dhkv_pkg::rsp_t apply_to_shadow(dhkv_pkg::req_t r);
    dhkv_pkg::rsp_t ans;
    longint         k;
    int unsigned    pos;
    int unsigned    a;
    int unsigned    stride;
    int unsigned    probes;
    bit             found;
    ans    = '0;
    k      = r.key;
    probes = 0;
    found  = 1'b0;
    if (r.operation != dhkv_pkg::OP_RESERVED) begin
      pos    = abs_rem(k, SLOTS) % SLOTS;
      a      = abs_rem(k, SLOTS - 1);
      stride = ((a % 2 == 0) ? a + 1 : a + 2) % SLOTS;
      while (!found && probes < SLOTS && shadow_state[pos] != dhkv_pkg::ST_EMPTY) begin
        if (shadow_state[pos] == dhkv_pkg::ST_LIVE && shadow_key[pos] == r.key) begin
          found = 1'b1;
        end else begin
          probes++;
          pos = (pos + stride) % SLOTS;
        end
      end
      if (found) begin
        ans.hit       = 1'b1;
        ans.old_value = shadow_val[pos];
        if (r.operation == dhkv_pkg::OP_INSERT) begin
          shadow_val[pos] = r.value;
        end else if (r.operation == dhkv_pkg::OP_REMOVE) begin
          shadow_state[pos] = dhkv_pkg::ST_TOMB;
          if (shadow_live > 0) shadow_live--;
        end
      end else if (r.operation == dhkv_pkg::OP_INSERT) begin
        if (probes < SLOTS) begin
          shadow_state[pos] = dhkv_pkg::ST_LIVE;
          shadow_key[pos]   = r.key;
          shadow_val[pos]   = r.value;
          shadow_live++;
        end else begin
          ans.full_error = 1'b1;
        end
      end
    end
    ans.entry_total = shadow_live;
    return ans;
  endfunction

  task automatic row_fixed(dhkv_pkg::op_t op, logic signed [31:0] k,
                           logic signed [31:0] v, logic h, logic signed [31:0] old,
                           logic fe, logic [4:0] tot);
    table_row_t row;
    row.item  = '{operation: op, key: k, value: v};
    row.fixed = 1'b1;
    row.given = '{hit: h, old_value: old, full_error: fe, entry_total: tot};
    directed_rows.push_back(row);
    if (op == dhkv_pkg::OP_INSERT) stored_keys.push_back(k);
  endtask

  task automatic row_predicted(dhkv_pkg::op_t op, logic signed [31:0] k,
                               logic signed [31:0] v);
    table_row_t row;
    row.item  = '{operation: op, key: k, value: v};
    row.fixed = 1'b0;
    row.given = '0;
    directed_rows.push_back(row);
    if (op == dhkv_pkg::OP_INSERT) stored_keys.push_back(k);
  endtask

  // Offer one item after an idle gap counted from the core going free, hold until taken.
  task automatic send_item(dhkv_pkg::req_t item, int unsigned gap, bit fixed,
                           dhkv_pkg::rsp_t given);
    dhkv_pkg::rsp_t predicted;
    if (gap > 0) begin
      if (start) start <= 1'b0;
      do @(posedge clk); while (busy !== 1'b0);
      repeat (gap - 1) @(posedge clk);
    end
    start   <= 1'b1;
    request <= item;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = apply_to_shadow(item);
    answers.push_back(fixed ? given : predicted);
    items_sent++;
  endtask

  task automatic drain_answers();
    if (start) start <= 1'b0;
    while (answers.size() != 0) @(posedge clk);
  endtask

  task automatic note_fault(string field, longint want, longint got);
    faults++;
    if (faults <= 10)
      $display("[%0t] %s mismatch: expected %0d, got %0d", $realtime, field, want, got);
  endtask

  // reply checker and watchdog
  always @(posedge clk) begin
    dhkv_pkg::rsp_t want;
    if (!rst && done) begin
      replies++;
      if (response.hit === 1'b1) hits_seen++;
      if (response.full_error === 1'b1) fulls_seen++;
      if (answers.size() == 0) begin
        note_fault("unsolicited reply, entry_total", -1, response.entry_total);
      end else begin
        want = answers.pop_front();
        if (response.hit !== want.hit) note_fault("hit", want.hit, response.hit);
        if (response.old_value !== want.old_value)
          note_fault("old_value", want.old_value, response.old_value);
        if (response.full_error !== want.full_error)
          note_fault("full_error", want.full_error, response.full_error);
        if (response.entry_total !== want.entry_total)
          note_fault("entry_total", want.entry_total, response.entry_total);
      end
    end
    if ((start && busy === 1'b0) || done === 1'b1) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog: no handshake for %0d cycles, %0d replies outstanding",
                 idle_cycles, answers.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    dhkv_pkg::req_t     item;
    logic signed [31:0] k;
    logic signed [31:0] v;
    int unsigned        pick;
    int unsigned        gap;
    bit                 burst;
    rst     = 1'b1;
    start   = 1'b0;
    request = '0;
    foreach (shadow_state[i]) begin
      shadow_state[i] = dhkv_pkg::ST_EMPTY;
      shadow_key[i]   = '0;
      shadow_val[i]   = '0;
    end
    shadow_live = '0;

    // Empty table, extremes, update on a hit, tombstone skip, then fill to saturation.
    row_fixed(dhkv_pkg::OP_SEARCH,   32'sd0,  32'sd0,  1'b0, 32'sd0,  1'b0, 5'd0);
    row_fixed(dhkv_pkg::OP_REMOVE,   32'sd0,  32'sd0,  1'b0, 32'sd0,  1'b0, 5'd0);
    row_fixed(dhkv_pkg::OP_RESERVED, KEY_MAX, KEY_MAX, 1'b0, 32'sd0,  1'b0, 5'd0);
    row_fixed(dhkv_pkg::OP_INSERT,   KEY_MAX, KEY_MIN, 1'b0, 32'sd0,  1'b0, 5'd1);
    row_fixed(dhkv_pkg::OP_INSERT,   KEY_MIN, KEY_MAX, 1'b0, 32'sd0,  1'b0, 5'd2);
    row_fixed(dhkv_pkg::OP_SEARCH,   KEY_MAX, 32'sd0,  1'b1, KEY_MIN, 1'b0, 5'd2);
    row_fixed(dhkv_pkg::OP_INSERT,   KEY_MAX, 32'sd5,  1'b1, KEY_MIN, 1'b0, 5'd2);
    row_fixed(dhkv_pkg::OP_REMOVE,   KEY_MIN, 32'sd0,  1'b1, KEY_MAX, 1'b0, 5'd1);
    row_predicted(dhkv_pkg::OP_SEARCH, KEY_MIN, 32'sd0);
    row_predicted(dhkv_pkg::OP_INSERT, -32'sd1, -32'sd1);
    row_predicted(dhkv_pkg::OP_INSERT, KEY_MIN, 32'sd0);
    for (int s = 2; s <= 14; s++) begin
      if (s != 9) row_predicted(dhkv_pkg::OP_INSERT, s, s * 3);
    end
    row_fixed(dhkv_pkg::OP_INSERT, 32'sd100, 32'sd7, 1'b0, 32'sd0, 1'b1, 5'd15);
    row_predicted(dhkv_pkg::OP_SEARCH, 32'sd12345, 32'sd0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].item, $urandom_range(0, GAP_MAX),
                directed_rows[i].fixed, directed_rows[i].given);
    end
    drain_answers();

    // The table never gets empty slots back, so work mostly on the stored keys.
    burst = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) burst = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_ITEMS / 2) drain_answers();
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 9) < 7) begin
        k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
      end else begin
        case ($urandom_range(0, 7))
          0:       k = KEY_MAX;
          1:       k = KEY_MIN;
          2:       k = -32'sd1;
          default: k = $urandom;
        endcase
      end
      case ($urandom_range(0, 5))
        0:       v = KEY_MAX;
        1:       v = KEY_MIN;
        default: v = $urandom;
      endcase
      item.key   = k;
      item.value = v;
      if (pick < 40)      item.operation = dhkv_pkg::OP_INSERT;
      else if (pick < 90) item.operation = dhkv_pkg::OP_SEARCH;
      else if (pick < 93) item.operation = dhkv_pkg::OP_REMOVE;
      else                item.operation = dhkv_pkg::OP_RESERVED;
      gap = burst ? 0 : $urandom_range(0, GAP_MAX);
      send_item(item, gap, 1'b0, '0);
    end

    drain_answers();
    repeat (SETTLE) @(posedge clk);
    if (answers.size() != 0) faults++;

    $display("Ran %0d operations to %0d replies: %0d hits, %0d rejected on a saturated table.",
             items_sent, replies, hits_seen, fulls_seen);
    $display("Mismatches counted: %0d; %0d entries still live at the end.", faults, shadow_live);
    if (faults == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/dhkv_pkg.sv
rtl/double_hash_key_value_table_core.sv
tb/double_hash_key_value_table_core_tb.sv
